### rtl/ipq_pkg.sv
// Shared types and constants for the IPv4 dotted-quad parser.
// No dependencies.
package ipq_pkg;

  localparam logic [4:0] MIN_TEXT_LEN   = 5'd7;
  localparam logic [4:0] MAX_TEXT_LEN   = 5'd15;
  localparam logic [4:0] LEN_SATURATE   = 5'd16;
  localparam logic [2:0] MAX_RUN_DIGITS = 3'd3;
  localparam logic [2:0] DIGIT_SATURATE = 3'd4;
  localparam logic [2:0] QUAD_RUNS      = 3'd4;
  localparam logic [9:0] MAX_OCTET      = 10'd255;
  localparam logic [7:0] DOT_CHAR       = 8'h2E;
  localparam logic [7:0] DIGIT_LO       = 8'h30;
  localparam logic [7:0] DIGIT_HI       = 8'h39;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic       is_valid;
    logic [7:0] octet_first;
    logic [7:0] octet_second;
    logic [7:0] octet_third;
    logic [7:0] octet_fourth;
  } out_word_t;

endpackage

### rtl/ipq_in_stage.sv
// Input register stage for the dotted-quad parser.
// Depends on ipq_pkg.
module ipq_in_stage import ipq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  input  logic     out_free_i,   // result register can take a word this cycle
  output logic     step_o,       // held word is consumed this cycle
  output in_word_t word_o
);

  logic     valid_q, valid_d;
  in_word_t word_q;

  // A non-final character never waits; the final one waits for the result slot.
  assign step_o     = valid_q && (!word_q.last_char || out_free_i);
  assign in_ready_o = !valid_q || step_o;
  assign word_o     = word_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= in_word_i;
    end
  end

endmodule

### rtl/ipq_scan.sv
// Running parse state and result logic for the dotted-quad parser.
// Depends on ipq_pkg.
module ipq_scan import ipq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_word_t  word_i,
  output out_word_t result_o
);

  logic [4:0] len_q, len_d;
  logic [2:0] run_q, run_d;
  logic [2:0] dcnt_q, dcnt_d;
  logic [9:0] val_q, val_d;
  logic       err_q, err_d;
  logic [7:0] store_q [4];
  logic [7:0] store_d [4];
  logic       is_dot, is_digit, ok;

  always_comb begin
    is_dot   = (word_i.text_char == DOT_CHAR);
    is_digit = (word_i.text_char inside {[DIGIT_LO:DIGIT_HI]});

    len_d  = (len_q < LEN_SATURATE) ? len_q + 5'd1 : len_q;
    dcnt_d = dcnt_q;
    val_d  = val_q;
    err_d  = err_q;
    run_d  = run_q;
    store_d = store_q;

    if (is_digit) begin
      // val_q stays below 100 while fewer than three digits are in
      if (dcnt_q < MAX_RUN_DIGITS) begin
        val_d = (val_q << 3) + (val_q << 1) + {6'd0, word_i.text_char[3:0]};
      end
      if (dcnt_q < DIGIT_SATURATE) begin
        dcnt_d = dcnt_q + 3'd1;
      end
    end else if (!is_dot) begin
      err_d = 1'b1;
    end

    // close the open run on a dot or at the end of the text
    if (is_dot || word_i.last_char) begin
      if (dcnt_d != 3'd0) begin
        if (run_q >= QUAD_RUNS) begin
          err_d = 1'b1;
        end else if (dcnt_d > MAX_RUN_DIGITS || val_d > MAX_OCTET) begin
          err_d = 1'b1;
        end else begin
          store_d[run_q[1:0]] = val_d[7:0];
          run_d = run_q + 3'd1;
        end
      end
      dcnt_d = 3'd0;
      val_d  = 10'd0;
    end

    ok = !err_d && (run_d == QUAD_RUNS) &&
         (len_d >= MIN_TEXT_LEN) && (len_d <= MAX_TEXT_LEN);

    result_o.is_valid     = ok;
    result_o.octet_first  = ok ? store_d[0] : 8'd0;
    result_o.octet_second = ok ? store_d[1] : 8'd0;
    result_o.octet_third  = ok ? store_d[2] : 8'd0;
    result_o.octet_fourth = ok ? store_d[3] : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      run_q   <= '0;
      dcnt_q  <= '0;
      val_q   <= '0;
      err_q   <= 1'b0;
      store_q <= '{default: '0};
    end else if (step_i) begin
      if (word_i.last_char) begin
        len_q   <= '0;
        run_q   <= '0;
        dcnt_q  <= '0;
        val_q   <= '0;
        err_q   <= 1'b0;
        store_q <= '{default: '0};
      end else begin
        len_q   <= len_d;
        run_q   <= run_d;
        dcnt_q  <= dcnt_d;
        val_q   <= val_d;
        err_q   <= err_d;
        store_q <= store_d;
      end
    end
  end

endmodule

### rtl/ipq_out_stage.sv
// Result register for the dotted-quad parser.
// Depends on ipq_pkg.
module ipq_out_stage import ipq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_word_t result_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic      valid_q, valid_d;
  out_word_t word_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= result_i;
    end
  end

endmodule

### rtl/ipv4_dotted_quad_parser.sv
// IPv4 dotted-quad text parser, top level.
// Depends on ipq_pkg, ipq_in_stage, ipq_scan, ipq_out_stage.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_word_i): one text character per
//   word, last_char set on the final character of an address.
//   Output channel (out_valid_o / out_ready_i / out_word_o): one word per
//   address, is_valid plus four octets; octets are zero when is_valid is 0.
//   A text is valid when it is 7..15 characters with exactly four non-empty
//   dot-separated runs of 1..3 digits, each at most 255. Empty runs from
//   extra dots are skipped.
// Throughput: one character per cycle while no final character waits;
//   the parse state update is a single pass of short logic between the
//   input and result registers.
// Result path: final character in the input register, then result register.
// Stall: a waiting result does not block non-final characters of the next
//   text; only a final character holds in the input register until the
//   result register frees, and then in_ready_o drops.
// Reset: asynchronous, active low; clears all handshake state and the
//   partial parse. State also clears after every result.
module ipv4_dotted_quad_parser import ipq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic      out_free;
  logic      step;
  in_word_t  held_word;
  out_word_t result;

  // input register
  ipq_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_free_i (out_free),
    .step_o     (step),
    .word_o     (held_word)
  );

  // parse state: counters, run value, error flag, octet store
  ipq_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .word_i   (held_word),
    .result_o (result)
  );

  // result register, loaded only on the final character
  ipq_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && held_word.last_char),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

### rtl/ipq_checker.sv
// Port-level checks for the dotted-quad parser, bound to the top level.
// Depends on ipq_pkg and ipv4_dotted_quad_parser.
module ipq_checker import ipq_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_word_o))
    else $error("result changed while stalled");

  // invalid text reports zero octets
  a_zero_on_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.is_valid |->
      out_word_o.octet_first == 8'd0 && out_word_o.octet_second == 8'd0 &&
      out_word_o.octet_third == 8'd0 && out_word_o.octet_fourth == 8'd0)
    else $error("nonzero octets on invalid result");

  // an empty result slot never backs up the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

bind ipv4_dotted_quad_parser ipq_checker u_ipq_checker (.*);

### tb/sv/ipq_parse_checker.sv
// Scoreboard for the IPv4 dotted-quad parser: watches both channels, predicts each result word.
// Depends on ipq_pkg for the word types and parse constants.
module ipq_parse_checker import ipq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_word_t   out_word_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted parse state
  logic [4:0] text_len;
  logic [2:0] runs_done;
  logic [2:0] run_digits;
  logic [9:0] run_acc;
  logic       bad_text;
  logic [7:0] octets [4];

  out_word_t  quad_q [$];

  function automatic void clear_parse();
    text_len   = '0;
    runs_done  = '0;
    run_digits = '0;
    run_acc    = '0;
    bad_text   = 1'b0;
    for (int k = 0; k < 4; k++) octets[k] = '0;
  endfunction

  // close the open run; empty runs vanish
  function automatic void finish_run();
    if (run_digits != 0) begin
      if (runs_done >= QUAD_RUNS) begin
        bad_text = 1'b1;
      end else if (run_digits > MAX_RUN_DIGITS || run_acc > MAX_OCTET) begin
        bad_text = 1'b1;
      end else begin
        octets[runs_done[1:0]] = run_acc[7:0];
        runs_done++;
      end
    end
    run_digits = '0;
    run_acc    = '0;
  endfunction

  task automatic take_char(input in_word_t w);
    logic      ok;
    out_word_t quad;
    if (text_len < LEN_SATURATE) text_len++;
    if (w.text_char == DOT_CHAR) begin
      finish_run();
    end else if (w.text_char >= DIGIT_LO && w.text_char <= DIGIT_HI) begin
      if (run_digits < MAX_RUN_DIGITS) run_acc = 10'(run_acc * 10 + (w.text_char - DIGIT_LO));
      if (run_digits < DIGIT_SATURATE) run_digits++;
    end else begin
      bad_text = 1'b1;
    end
    if (w.last_char) begin
      finish_run();
      ok = !bad_text && runs_done == QUAD_RUNS &&
           text_len >= MIN_TEXT_LEN && text_len <= MAX_TEXT_LEN;
      quad = '0;
      if (ok) begin
        quad = '{is_valid: 1'b1, octet_first: octets[0], octet_second: octets[1],
                 octet_third: octets[2], octet_fourth: octets[3]};
      end
      quad_q.push_back(quad);
      clear_parse();
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_quad(input out_word_t got);
    out_word_t want;
    if (quad_q.size() == 0) begin
      $error("result word %h with none expected", got);
      fail_count_o++;
    end else begin
      want = quad_q.pop_front();
      check_field("is_valid", 8'(want.is_valid), 8'(got.is_valid));
      check_field("octet_first", want.octet_first, got.octet_first);
      check_field("octet_second", want.octet_second, got.octet_second);
      check_field("octet_third", want.octet_third, got.octet_third);
      check_field("octet_fourth", want.octet_fourth, got.octet_fourth);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      quad_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_quad(out_word_i);
      if (in_valid_i && in_ready_i) take_char(in_word_i);
    end
    pending_o <= quad_q.size();
  end

endmodule

### tb/sv/tb_ipv4_dotted_quad_parser.sv
// Testbench top for the IPv4 dotted-quad parser: drives address texts, gives the verdict.
// Depends on ipq_pkg, ipv4_dotted_quad_parser and ipq_parse_checker.
module tb_ipv4_dotted_quad_parser import ipq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHAR_TARGET  = 1700;    // stop making texts past this many chars
  localparam int unsigned PAUSE_TEXT   = 60;      // sender drains all results before this text
  localparam int unsigned CALM_FIRST   = 120;     // texts in [CALM_FIRST, CALM_LAST) run flat out
  localparam int unsigned CALM_LAST    = 150;
  localparam int unsigned HOLD_START   = 500;     // sink cycle that starts the long back-pressure
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_PCT     = 21;
  localparam int unsigned DRAIN_CYCLES = 6;       // input and result registers plus margin
  localparam int unsigned TIMEOUT_NS   = 2000000;

  // ways to spoil an otherwise good quad
  typedef enum int unsigned {
    FLAW_SWAP_CHAR,
    FLAW_EXTRA_DIGIT,
    FLAW_BIG_RUN,
    FLAW_FIVE_RUNS,
    FLAW_THREE_RUNS,
    FLAW_DROP_CHAR,
    FLAW_CUT
  } flaw_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_word_t    in_word   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  int unsigned fail_count;
  int unsigned pending;

  bit          calm_phase = 1'b0;   // no idling on either side while set
  int unsigned chars_sent = 0;
  logic [7:0]  text_q [$];          // text being built, one char per word

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ipv4_dotted_quad_parser u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  ipq_parse_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // --- text construction ------------------------------------------------

  // octet values lean small so that short (7 char) quads show up often
  function automatic int unsigned pick_octet();
    case ($urandom_range(3))
      0:       return $urandom_range(9);
      1:       return $urandom_range(99);
      2:       return $urandom_range(255);
      default: return $urandom_range(1) ? 255 : 0;
    endcase
  endfunction

  // decimal digits of val, left-padded with zeros to min_digits
  task automatic push_number(input int unsigned val, input int unsigned min_digits);
    logic [7:0]  digs [$];
    int unsigned v;
    v = val;
    do begin
      digs.push_front(8'(DIGIT_LO + v % 10));
      v = v / 10;
    end while (v != 0);
    while (digs.size() < min_digits) digs.push_front(DIGIT_LO);
    text_q = {text_q, digs};
  endtask

  // runs dot-separated octets; loose adds stray dots that should be skipped;
  // the run at bad_run (if < runs) gets a value that is too big or too long
  task automatic build_quad(input int unsigned runs, input bit loose, input int unsigned bad_run);
    int unsigned pad;
    text_q.delete();
    if (loose && $urandom_range(3) == 0) text_q.push_back(DOT_CHAR);
    for (int k = 0; k < runs; k++) begin
      if (k != 0) begin
        text_q.push_back(DOT_CHAR);
        if (loose && $urandom_range(3) == 0) text_q.push_back(DOT_CHAR);
      end
      pad = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 1;
      if (k == bad_run) begin
        push_number($urandom_range(1) ? $urandom_range(256, 999) : $urandom_range(1000, 99999), 1);
      end else begin
        push_number(pick_octet(), pad);
      end
    end
    if (loose && $urandom_range(3) == 0) text_q.push_back(DOT_CHAR);
  endtask

  task automatic load_string(input string s);
    text_q.delete();
    for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
  endtask

  // random bytes, biased toward digits and dots so partial quads form
  task automatic build_noise();
    int unsigned n;
    text_q.delete();
    n = $urandom_range(1, 20);
    repeat (n) begin
      case ($urandom_range(3))
        0, 1:    text_q.push_back(8'(DIGIT_LO + $urandom_range(9)));
        2:       text_q.push_back(DOT_CHAR);
        default: text_q.push_back(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic build_broken();
    flaw_e       flaw;
    int unsigned idx;
    flaw = flaw_e'($urandom_range(FLAW_CUT));
    case (flaw)
      FLAW_BIG_RUN:    build_quad(4, $urandom_range(1), $urandom_range(3));
      FLAW_FIVE_RUNS:  build_quad(5, $urandom_range(1), 5);
      FLAW_THREE_RUNS: build_quad(3, $urandom_range(1), 3);
      default:         build_quad(4, $urandom_range(1), 4);
    endcase
    idx = $urandom_range(text_q.size() - 1);
    case (flaw)
      FLAW_SWAP_CHAR:   text_q[idx] = 8'($urandom_range(255));
      FLAW_EXTRA_DIGIT: text_q.insert(idx, 8'(DIGIT_LO + $urandom_range(9)));
      FLAW_DROP_CHAR:   if (text_q.size() > 1) text_q.delete(idx);
      FLAW_CUT: begin
        if (text_q.size() > 1) begin
          idx = $urandom_range(1, text_q.size() - 1);
          while (text_q.size() > idx) void'(text_q.pop_back());
        end
      end
      default: ;
    endcase
  endtask

  // --- driving ----------------------------------------------------------

  // one word on the input channel; returns on the edge that accepts it
  task automatic send_word(input logic [7:0] ch, input logic lst);
    while (!calm_phase && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{text_char: ch, last_char: lst};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[k]) send_word(text_q[k], k == text_q.size() - 1);
  endtask

  // drop valid and wait for every predicted result word to come back;
  // the first edge lets the checker's count catch up with the last word
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // --- stimulus ---------------------------------------------------------

  initial begin : text_source
    int unsigned text_idx;
    int unsigned pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all-max quad, a fifth run, zero byte alone, top byte alone
    load_string("255.255.255.255");
    send_text();
    load_string("1.2.3.4.5");
    send_text();
    text_q = {8'h00};
    send_text();
    text_q = {8'hFF};
    send_text();

    // random: mostly good quads (some with stray dots), mixed with broken ones and noise
    text_idx = 0;
    while (chars_sent < CHAR_TARGET) begin
      if (text_idx == PAUSE_TEXT) drain_results();
      calm_phase = (text_idx >= CALM_FIRST && text_idx < CALM_LAST);
      pick = $urandom_range(99);
      if (pick < 35)      build_quad(4, 1'b0, 4);
      else if (pick < 55) build_quad(4, 1'b1, 4);
      else if (pick < 85) build_broken();
      else                build_noise();
      send_text();
      text_idx++;
    end
    calm_phase = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off that backs the block up
  // into its input, and full speed while the calm window is open
  initial begin : result_sink
    int unsigned cyc;
    int unsigned hold_left;
    cyc       = 0;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == HOLD_START) hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm_phase) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
rtl/ipq_pkg.sv
rtl/ipq_in_stage.sv
rtl/ipq_scan.sv
rtl/ipq_out_stage.sv
rtl/ipv4_dotted_quad_parser.sv
rtl/ipq_checker.sv
tb/sv/ipq_parse_checker.sv
tb/sv/tb_ipv4_dotted_quad_parser.sv
